// ===== rtl/gcm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gcm_pkg;

   localparam int unsigned DENOM_COUNT_DEFAULT = 13;
   localparam int unsigned TABLE_SLOTS         = 16;

   localparam int unsigned AMOUNT_W = 24;
   localparam int unsigned INDEX_W  = 4;
   localparam int unsigned DENOM_W  = 15;
   localparam int unsigned CNT_W    = 10;
   localparam int unsigned REM_W    = 15;

   // floor(x / 20000) == (x * RECIP_MULT) >> RECIP_SHIFT for every 24-bit x
   localparam int unsigned RECIP_W     = 25;
   localparam int unsigned RECIP_SHIFT = 39;
   localparam int unsigned PROD_W      = AMOUNT_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_MULT = 25'd27487791;

   // largest ratio between neighboring denominations
   localparam int unsigned MAX_RATIO = 5;
   localparam int unsigned QUOT_W    = 3;
   localparam int unsigned THR_W     = 18;

   localparam logic [DENOM_W-1:0] DENOM_TABLE [TABLE_SLOTS] = '{
      15'd20000, 15'd10000, 15'd5000, 15'd2000, 15'd1000, 15'd500, 15'd200, 15'd100,
      15'd50, 15'd20, 15'd10, 15'd5, 15'd1, 15'd1, 15'd1, 15'd1
   };

endpackage

`default_nettype wire

// ===== rtl/greedy_change_maker.sv =====
// Greedy change maker.
// Input channel (req_): one amount in cents per transfer, req_amount_cents.
// Result channel (rsp_): DENOM_COUNT transfers per amount, one per
// denomination, largest first, zero counts included; rsp_is_last marks the
// smallest denomination. Each result carries its table index, the value of
// the denomination in cents and the count of pieces.
// The datapath is a pipeline of DENOM_COUNT + 1 stages (a reciprocal
// multiply, then one stage per denomination) and takes a new amount in
// every cycle while it has room. The rate of amounts is set by the result
// channel, which moves one result per cycle out of the output shift
// register while rsp_stall is low.
// Reset clears all valid bits and the result counter; nothing else is kept.
// rsp_stall holds the current result; the pipeline keeps filling behind it
// and then raises req_stall. No item is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module greedy_change_maker
   import gcm_pkg::*;
#(
   parameter int unsigned DENOM_COUNT = DENOM_COUNT_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [AMOUNT_W-1:0] req_amount_cents,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [INDEX_W-1:0]       rsp_denom_index,
   output logic [DENOM_W-1:0]       rsp_denom_cents,
   output logic [CNT_W-1:0]         rsp_coin_count,
   output logic                     rsp_is_last
);

   localparam int unsigned USED = (DENOM_COUNT > TABLE_SLOTS) ? TABLE_SLOTS :
                                  ((DENOM_COUNT < 1) ? 1 : DENOM_COUNT);
   localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(USED - 1);

   typedef logic [USED-1:0][CNT_W-1:0] cnt_vec_type;

   // multiply stage
   logic                mul_valid_ff;
   logic [AMOUNT_W-1:0] mul_amount_ff;
   logic [CNT_W-1:0]    mul_q_ff;
   logic [PROD_W-1:0]   mul_prod;
   logic                mul_ready;

   // denomination stages
   logic              pipe_valid_ff [USED];
   logic [REM_W-1:0]  pipe_rem_ff   [USED];
   cnt_vec_type       pipe_cnt_ff   [USED];
   logic [REM_W-1:0]  pipe_rem_in   [USED];
   cnt_vec_type       pipe_cnt_in   [USED];
   logic [USED:0]     pipe_ready;

   // output shift register
   logic               ser_valid_ff;
   logic [INDEX_W-1:0] ser_idx_ff;
   cnt_vec_type        ser_cnt_ff;
   logic               ser_last;
   logic               ser_ready;
   logic               rsp_xfer;

   assign mul_prod  = PROD_W'(req_amount_cents) * PROD_W'(RECIP_MULT);
   assign mul_ready = !mul_valid_ff || pipe_ready[0];
   assign req_stall = !mul_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (mul_ready) begin
         mul_valid_ff <= req_valid;
      end
      if (mul_ready && req_valid) begin
         mul_amount_ff <= req_amount_cents;
         mul_q_ff      <= mul_prod[RECIP_SHIFT +: CNT_W];
      end
   end

   always_comb begin
      pipe_rem_in[0] = REM_W'(mul_amount_ff
                              - (AMOUNT_W'(mul_q_ff) * AMOUNT_W'(DENOM_TABLE[0])));
      pipe_cnt_in[0]    = '0;
      pipe_cnt_in[0][0] = mul_q_ff;
   end

   generate
      for (genvar p = 1; p < USED; p++) begin : g_stage
         always_comb begin
            logic [QUOT_W-1:0] q;
            logic [THR_W-1:0]  thr;
            q = '0;
            for (int m = 1; m <= MAX_RATIO; m++) begin
               thr = THR_W'(m) * THR_W'(DENOM_TABLE[p]);
               if (THR_W'(pipe_rem_ff[p-1]) >= thr) begin
                  q = QUOT_W'(m);
               end
            end
            pipe_rem_in[p] = REM_W'(THR_W'(pipe_rem_ff[p-1])
                                    - (THR_W'(q) * THR_W'(DENOM_TABLE[p])));
            pipe_cnt_in[p]    = pipe_cnt_ff[p-1];
            pipe_cnt_in[p][p] = CNT_W'(q);
         end
      end
   endgenerate

   generate
      for (genvar p = 0; p < USED; p++) begin : g_pipe
         logic src_valid;
         if (p == 0) begin : g_first
            assign src_valid = mul_valid_ff;
         end else begin : g_next
            assign src_valid = pipe_valid_ff[p-1];
         end

         assign pipe_ready[p] = !pipe_valid_ff[p] || pipe_ready[p+1];

         always_ff @(posedge clock) begin
            if (reset) begin
               pipe_valid_ff[p] <= 1'b0;
            end else if (pipe_ready[p]) begin
               pipe_valid_ff[p] <= src_valid;
            end
            if (pipe_ready[p] && src_valid) begin
               pipe_rem_ff[p] <= pipe_rem_in[p];
               pipe_cnt_ff[p] <= pipe_cnt_in[p];
            end
         end
      end
   endgenerate

   assign rsp_xfer         = ser_valid_ff && !rsp_stall;
   assign ser_last         = (ser_idx_ff == LAST_INDEX);
   assign ser_ready        = !ser_valid_ff || (rsp_xfer && ser_last);
   assign pipe_ready[USED] = ser_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         ser_valid_ff <= 1'b0;
         ser_idx_ff   <= '0;
      end else if (ser_ready && pipe_valid_ff[USED-1]) begin
         ser_valid_ff <= 1'b1;
         ser_idx_ff   <= '0;
      end else if (rsp_xfer && ser_last) begin
         ser_valid_ff <= 1'b0;
      end else if (rsp_xfer) begin
         ser_idx_ff <= ser_idx_ff + 1'b1;
      end
      if (ser_ready && pipe_valid_ff[USED-1]) begin
         ser_cnt_ff <= pipe_cnt_ff[USED-1];
      end else if (rsp_xfer) begin
         ser_cnt_ff <= ser_cnt_ff >> CNT_W;
      end
   end

   assign rsp_valid       = ser_valid_ff;
   assign rsp_denom_index = ser_idx_ff;
   assign rsp_denom_cents = DENOM_TABLE[ser_idx_ff];
   assign rsp_coin_count  = ser_cnt_ff[0];
   assign rsp_is_last     = ser_last;

   a_small_counts : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_denom_index != '0) |-> rsp_coin_count <= CNT_W'(MAX_RATIO))
      else $error("count above denomination ratio");

   a_index_step : assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && !ser_last |=> rsp_valid && (rsp_denom_index == $past(rsp_denom_index) + 1'b1))
      else $error("result sequence broken");

   a_index_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_denom_index <= LAST_INDEX)
      else $error("denomination index out of range");

   a_tail_hold : assert property (@(posedge clock) disable iff (reset)
      pipe_valid_ff[USED-1] && !ser_ready |=> pipe_valid_ff[USED-1])
      else $error("pipeline tail dropped");

   a_stall_full : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> mul_valid_ff && pipe_valid_ff[0])
      else $error("stall without full front");

endmodule

`default_nettype wire

// ===== tb/greedy_change_maker_tb.sv =====
`timescale 1ns / 1ps

module greedy_change_maker_tb;
   import gcm_pkg::*;

   localparam int unsigned PIECE_KINDS  = 13;
   localparam int unsigned CYCLE_LIMIT  = 300000;
   localparam int unsigned DRAIN_CYCLES = 40;
   localparam int unsigned HOLD_CYCLES  = 400;

   typedef enum int {
      STALL_NONE,
      STALL_RANDOM,
      STALL_BURSTY
   } stall_mode_type;

   typedef struct {
      logic [INDEX_W-1:0] index;
      logic [DENOM_W-1:0] cents;
      logic [CNT_W-1:0]   count;
      logic               last;
   } piece_type;

   localparam int unsigned DENOMS [PIECE_KINDS] = '{
      20000, 10000, 5000, 2000, 1000, 500, 200, 100, 50, 20, 10, 5, 1
   };

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [AMOUNT_W-1:0] req_amount_cents = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [INDEX_W-1:0]  rsp_denom_index;
   logic [DENOM_W-1:0]  rsp_denom_cents;
   logic [CNT_W-1:0]    rsp_coin_count;
   logic                rsp_is_last;

   piece_type      pending_pieces [$];
   int unsigned    mismatches = 0;
   int unsigned    cycle_count = 0;
   stall_mode_type stall_mode = STALL_NONE;
   int unsigned    hold_request = 0;
   int unsigned    hold_left = 0;
   int unsigned    run_left = 0;
   logic           run_stalled = 1'b0;

   greedy_change_maker uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_amount_cents (req_amount_cents),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_denom_index  (rsp_denom_index),
      .rsp_denom_cents  (rsp_denom_cents),
      .rsp_coin_count   (rsp_coin_count),
      .rsp_is_last      (rsp_is_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic void break_into_pieces(input logic [AMOUNT_W-1:0] amount);
      int unsigned remaining;
      int unsigned pieces;
      piece_type   p;
      remaining = 32'(amount);
      for (int k = 0; k < PIECE_KINDS; k++) begin
         pieces    = remaining / DENOMS[k];
         remaining = remaining - pieces * DENOMS[k];
         p.index   = k[INDEX_W-1:0];
         p.cents   = DENOMS[k][DENOM_W-1:0];
         p.count   = pieces[CNT_W-1:0];
         p.last    = (k == PIECE_KINDS - 1);
         pending_pieces.push_back(p);
      end
   endfunction

   function automatic logic [AMOUNT_W-1:0] pick_amount();
      case ($urandom_range(0, 3))
         0: return AMOUNT_W'($urandom());
         1: return AMOUNT_W'($urandom_range(0, 19999));
         2: return AMOUNT_W'($urandom_range(0, 199));
         default: return AMOUNT_W'($urandom_range(0, 838) * 20000 + $urandom_range(0, 17215));
      endcase
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   // one transfer on the input channel; valid stays high for a following item
   task automatic send_amount(input logic [AMOUNT_W-1:0] amount);
      req_valid        <= 1'b1;
      req_amount_cents <= amount;
      do @(posedge clock); while (req_stall);
      break_into_pieces(amount);
   endtask

   task automatic idle_input(input int unsigned cycles);
      if (cycles > 0) begin
         req_valid        <= 1'b0;
         req_amount_cents <= AMOUNT_W'($urandom());
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic send_bursts(input int unsigned items);
      int unsigned burst;
      while (items > 0) begin
         burst = $urandom_range(1, 8);
         if (burst > items) burst = items;
         repeat (burst) send_amount(pick_amount());
         items -= burst;
         idle_input($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20));
      end
      idle_input(1);
   endtask

   task automatic test_directed_amounts();
      logic [AMOUNT_W-1:0] amounts [$];
      amounts = {24'd0, 24'hFFFFFF, 24'hFFFFFE, 24'd1, 24'd4, 24'd19999, 24'd1999,
                 24'd16760000, 24'h800000, 24'h555555, 24'hAAAAAA};
      foreach (DENOMS[k]) amounts.push_back(AMOUNT_W'(DENOMS[k]));
      stall_mode = STALL_NONE;
      foreach (amounts[i]) send_amount(amounts[i]);
      idle_input(1);
   endtask

   task automatic test_random_bursts();
      stall_mode = STALL_RANDOM;
      send_bursts(180);
   endtask

   task automatic test_full_rate();
      stall_mode = STALL_NONE;
      repeat (80) send_amount(pick_amount());
      idle_input(1);
   endtask

   task automatic test_receiver_hold();
      stall_mode   = STALL_NONE;
      hold_request = HOLD_CYCLES;
      repeat (40) send_amount(pick_amount());
      idle_input(1);
   endtask

   task automatic test_bursty_receiver();
      stall_mode = STALL_BURSTY;
      send_bursts(110);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_request > 0) begin
         hold_left    = hold_request - 1;
         hold_request = 0;
         rsp_stall   <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            STALL_RANDOM: rsp_stall <= ($urandom_range(0, 99) < 35);
            STALL_BURSTY: begin
               if (run_left == 0) begin
                  run_stalled = ~run_stalled;
                  run_left    = run_stalled ? $urandom_range(1, 12) : $urandom_range(1, 20);
               end
               run_left--;
               rsp_stall <= run_stalled;
            end
            default: rsp_stall <= 1'b0;
         endcase
      end
   end

   always @(posedge clock) begin : check_results
      piece_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pieces.size() == 0) begin
            report_mismatch("unexpected transfer, denom_index", 32'(rsp_denom_index), 0);
         end else begin
            want = pending_pieces.pop_front();
            if (rsp_denom_index !== want.index)
               report_mismatch("denom_index", 32'(rsp_denom_index), 32'(want.index));
            if (rsp_denom_cents !== want.cents)
               report_mismatch("denom_cents", 32'(rsp_denom_cents), 32'(want.cents));
            if (rsp_coin_count !== want.count)
               report_mismatch("coin_count", 32'(rsp_coin_count), 32'(want.count));
            if (rsp_is_last !== want.last)
               report_mismatch("is_last", 32'(rsp_is_last), 32'(want.last));
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_amounts();
      test_random_bursts();
      test_full_rate();
      test_receiver_hold();
      test_bursty_receiver();

      stall_mode = STALL_NONE;
      while (pending_pieces.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
